// File: rtl/snfcs_pkg.sv
// ----------------------------------------------------------------------------
// snfcs_pkg
// Shared types, codes and constants of the SPI NOR flash command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package snfcs_pkg;

  localparam int unsigned PAGE_BYTES = 256;
  localparam int unsigned PAGE_W     = $clog2(PAGE_BYTES);
  localparam int unsigned CHUNK_W    = PAGE_W + 1;
  localparam int unsigned MAX_EMIT   = 6;
  localparam int unsigned SLOT_W     = $clog2(MAX_EMIT + 1);

  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_PROGRAM = 3'd1;
  localparam logic [2:0] OP_ERASE   = 3'd2;
  localparam logic [2:0] OP_IDENT   = 3'd3;
  localparam logic [2:0] OP_WBYTE   = 3'd4;
  localparam logic [2:0] OP_REPLY   = 3'd5;
  localparam logic [2:0] OP_TICK    = 3'd6;
  localparam logic [2:0] OP_NONE    = 3'd7;

  localparam logic [1:0] KIND_SPI  = 2'd0;
  localparam logic [1:0] KIND_HOST = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ALIGN   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_ID      = 2'd3;

  localparam logic [1:0] CFG_SECTOR_LOG2 = 2'd0;
  localparam logic [1:0] CFG_SECTOR_CNT  = 2'd1;
  localparam logic [1:0] CFG_PROG_TMO    = 2'd2;
  localparam logic [1:0] CFG_ERASE_TMO   = 2'd3;

  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_RDSR  = 8'h05;
  localparam logic [7:0] CMD_RDID  = 8'h9F;
  localparam logic [7:0] CMD_FREAD = 8'h0B;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_SE    = 8'hD8;
  localparam logic [7:0] ID_BYTE   = 8'h20;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [23:0] start_address;
    logic [24:0] byte_count;
    logic [7:0]  byte_in;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       capture;
    logic       frame_end;
    logic [1:0] status;
    logic       last;
  } out_word_t;

  // one slot of an emit list: a result without its last flag
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       capture;
    logic       frame_end;
    logic [1:0] status;
  } slot_t;

  typedef struct packed {
    logic [SLOT_W-1:0]         count;
    slot_t [MAX_EMIT-1:0]      slots;
  } burst_t;

  function automatic slot_t spi(input logic [7:0] b, input logic cap, input logic fe);
    slot_t s;
    s = '{kind: KIND_SPI, byte_out: b, capture: cap, frame_end: fe, status: ST_OK};
    return s;
  endfunction

  function automatic slot_t done(input logic [1:0] st);
    slot_t s;
    s = '{kind: KIND_DONE, byte_out: 8'd0, capture: 1'b0, frame_end: 1'b0, status: st};
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/spi_nor_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer
// Turns host read, program, erase and identify requests into SPI byte words.
// Path: input word registered in snfcs_front, burst registered in snfcs_back.
// Throughput: one result word per cycle while out_ready is high; an input
// word causes up to six result words, or none, before the next is taken.
// Reset: synchronous active-low; sequencer idle, registers at default values.
// ----------------------------------------------------------------------------
`default_nettype none
module spi_nor_flash_command_sequencer (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire snfcs_pkg::in_word_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output snfcs_pkg::out_word_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata
);

  logic [4:0]  sector_log2_r;
  logic [8:0]  sector_cnt_r;
  logic [11:0] prog_tmo_r;
  logic [15:0] erase_tmo_r;

  logic                q_valid, q_ready, q_misaligned;
  snfcs_pkg::in_word_t q_data;
  logic [7:0]          q_capacity;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_log2_r <= 5'd16;
      sector_cnt_r  <= 9'd32;
      prog_tmo_r    <= 12'd5;
      erase_tmo_r   <= 16'd3000;
    end else if (cfg_we) begin
      case (cfg_index)
        snfcs_pkg::CFG_SECTOR_LOG2: sector_log2_r <= cfg_wdata[4:0];
        snfcs_pkg::CFG_SECTOR_CNT:  sector_cnt_r  <= cfg_wdata[8:0];
        snfcs_pkg::CFG_PROG_TMO:    prog_tmo_r    <= cfg_wdata[11:0];
        snfcs_pkg::CFG_ERASE_TMO:   erase_tmo_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  snfcs_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .sector_log2 (sector_log2_r),
    .sector_cnt  (sector_cnt_r),
    .q_valid, .q_ready, .q_data, .q_misaligned, .q_capacity
  );

  snfcs_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data, .q_misaligned, .q_capacity,
    .sector_log2 (sector_log2_r),
    .prog_tmo    (prog_tmo_r),
    .erase_tmo   (erase_tmo_r),
    .out_valid, .out_ready, .out_data
  );

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == snfcs_pkg::KIND_DONE |-> out_data.last)
    else $error("finish word is not the last of its burst");

  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != snfcs_pkg::KIND_DONE |-> out_data.status == snfcs_pkg::ST_OK)
    else $error("status set on a non-finish word");

endmodule
`default_nettype wire

// File: rtl/snfcs_front.sv
// ----------------------------------------------------------------------------
// snfcs_front
// Input word register and classifier: drop OP_NONE words, compute the
// sector mask, alignment and expected capacity byte, then queue the word.
// ----------------------------------------------------------------------------
`default_nettype none
module snfcs_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire snfcs_pkg::in_word_t in_data,
  input  wire logic [4:0]          sector_log2,
  input  wire logic [8:0]          sector_cnt,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output snfcs_pkg::in_word_t      q_data,
  output logic                     q_misaligned,
  output logic [7:0]               q_capacity
);

  logic                 valid_r;
  snfcs_pkg::in_word_t  word_r;
  logic [24:0]          mask;
  logic [3:0]           cnt_lg;
  logic                 take;

  assign in_ready = !valid_r || q_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= (in_data.opcode != snfcs_pkg::OP_NONE);
    end else if (q_ready) begin
      valid_r <= 1'b0;
    end
    if (take) begin
      word_r <= in_data;
    end
  end

  always_comb begin
    cnt_lg = '0;
    for (int i = 1; i < 9; i++) begin
      if (sector_cnt[i]) cnt_lg = 4'(i);
    end
  end

  assign mask         = (25'd1 << sector_log2) - 25'd1;
  assign q_valid      = valid_r;
  assign q_data       = word_r;
  assign q_misaligned = ((word_r.start_address & mask[23:0]) != '0) ||
                        ((word_r.byte_count & mask) != '0);
  assign q_capacity   = (sector_cnt == '0) ? 8'd0 : 8'({3'd0, sector_log2} + {4'd0, cnt_lg});

endmodule
`default_nettype wire

// File: rtl/snfcs_back.sv
// ----------------------------------------------------------------------------
// snfcs_back
// Sequencer: runs request phases, emits up to six result words per input
// word, and streams them out one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
module snfcs_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 q_valid,
  output logic                      q_ready,
  input  wire snfcs_pkg::in_word_t  q_data,
  input  wire logic                 q_misaligned,
  input  wire logic [7:0]           q_capacity,
  input  wire logic [4:0]           sector_log2,
  input  wire logic [11:0]          prog_tmo,
  input  wire logic [15:0]          erase_tmo,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output snfcs_pkg::out_word_t      out_data
);

  typedef enum logic [5:0] {
    PH_IDLE       = 6'b000001,
    PH_RD_DATA    = 6'b000010,
    PH_PG_DATA    = 6'b000100,
    PH_POLL_WAIT  = 6'b001000,
    PH_POLL_REPLY = 6'b010000,
    PH_ID_REPLY   = 6'b100000
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [1:0]                      kind_r, kind_nxt;
  logic [23:0]                     addr_r, addr_nxt;
  logic [24:0]                     rem_r, rem_nxt;
  logic [snfcs_pkg::CHUNK_W-1:0]   chunk_r, chunk_nxt;
  logic [15:0]                     busy_r, busy_nxt;
  logic [1:0]                      idx_r, idx_nxt;
  logic                            mism_r, mism_nxt;

  snfcs_pkg::burst_t               burst_r, burst;
  logic [snfcs_pkg::SLOT_W-1:0]    pos_r;
  logic                            have_r;
  logic                            fire, last_slot;

  logic [24:0] sector;
  logic [snfcs_pkg::CHUNK_W-1:0] room;
  logic [24:0] rem_dec;
  logic [15:0] limit;
  logic [7:0]  want;

  assign last_slot = (pos_r == burst_r.count - snfcs_pkg::SLOT_W'(1));
  assign q_ready   = !have_r || (out_ready && last_slot);
  assign fire      = q_valid && q_ready;

  assign sector  = 25'd1 << sector_log2;
  assign room    = snfcs_pkg::CHUNK_W'(snfcs_pkg::PAGE_BYTES) -
                   snfcs_pkg::CHUNK_W'(addr_r[snfcs_pkg::PAGE_W-1:0]);
  assign rem_dec = rem_r - 25'd1;
  assign limit   = (kind_r == snfcs_pkg::OP_PROGRAM[1:0]) ? {4'd0, prog_tmo} : erase_tmo;
  assign want    = (idx_r < 2'd2) ? snfcs_pkg::ID_BYTE : q_capacity;

  always_comb begin
    logic [24:0] rem_sec;
    logic [23:0] a;
    logic [24:0] r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    addr_nxt  = addr_r;
    rem_nxt   = rem_r;
    chunk_nxt = chunk_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    mism_nxt  = mism_r;
    burst       = '0;
    rem_sec   = (rem_r >= sector) ? rem_r - sector : 25'd0;
    a         = addr_r;
    r         = rem_r;
    case (q_data.opcode)
      snfcs_pkg::OP_READ, snfcs_pkg::OP_PROGRAM,
      snfcs_pkg::OP_ERASE, snfcs_pkg::OP_IDENT: begin
        if (phase_r == PH_IDLE) begin
          a        = q_data.start_address;
          r        = q_data.byte_count;
          kind_nxt = q_data.opcode[1:0];
          addr_nxt = a;
          rem_nxt  = r;
          case (q_data.opcode)
            snfcs_pkg::OP_READ: begin
              burst.slots[0] = snfcs_pkg::spi(snfcs_pkg::CMD_FREAD, 1'b0, 1'b0);
              burst.slots[1] = snfcs_pkg::spi(a[23:16], 1'b0, 1'b0);
              burst.slots[2] = snfcs_pkg::spi(a[15:8], 1'b0, 1'b0);
              burst.slots[3] = snfcs_pkg::spi(a[7:0], 1'b0, 1'b0);
              if (r == '0) begin
                burst.slots[4] = snfcs_pkg::spi(8'h00, 1'b0, 1'b1);
                burst.slots[5] = snfcs_pkg::done(snfcs_pkg::ST_OK);
                burst.count    = 3'd6;
              end else begin
                burst.slots[4] = snfcs_pkg::spi(8'h00, 1'b0, 1'b0);
                burst.slots[5] = snfcs_pkg::spi(8'h00, 1'b1, r == 25'd1);
                burst.count    = 3'd6;
                rem_nxt        = r - 25'd1;
                phase_nxt      = PH_RD_DATA;
              end
            end
            snfcs_pkg::OP_PROGRAM: begin
              if (r == '0) begin
                burst.slots[0] = snfcs_pkg::done(snfcs_pkg::ST_OK);
                burst.count    = 3'd1;
              end else begin
                burst.slots[0] = snfcs_pkg::spi(snfcs_pkg::CMD_WREN, 1'b0, 1'b1);
                burst.slots[1] = snfcs_pkg::spi(snfcs_pkg::CMD_PP, 1'b0, 1'b0);
                burst.slots[2] = snfcs_pkg::spi(a[23:16], 1'b0, 1'b0);
                burst.slots[3] = snfcs_pkg::spi(a[15:8], 1'b0, 1'b0);
                burst.slots[4] = snfcs_pkg::spi(a[7:0], 1'b0, 1'b0);
                burst.count    = 3'd5;
                room_set: begin
                  logic [snfcs_pkg::CHUNK_W-1:0] rm;
                  rm = snfcs_pkg::CHUNK_W'(snfcs_pkg::PAGE_BYTES) -
                       snfcs_pkg::CHUNK_W'(a[snfcs_pkg::PAGE_W-1:0]);
                  chunk_nxt = (25'(rm) < r) ? rm : r[snfcs_pkg::CHUNK_W-1:0];
                end
                phase_nxt = PH_PG_DATA;
              end
            end
            snfcs_pkg::OP_ERASE: begin
              if (q_misaligned) begin
                burst.slots[0] = snfcs_pkg::done(snfcs_pkg::ST_ALIGN);
                burst.count    = 3'd1;
              end else if (r == '0) begin
                burst.slots[0] = snfcs_pkg::spi(snfcs_pkg::CMD_WREN, 1'b0, 1'b1);
                burst.slots[1] = snfcs_pkg::done(snfcs_pkg::ST_OK);
                burst.count    = 3'd2;
              end else begin
                burst.slots[0] = snfcs_pkg::spi(snfcs_pkg::CMD_WREN, 1'b0, 1'b1);
                burst.slots[1] = snfcs_pkg::spi(snfcs_pkg::CMD_WREN, 1'b0, 1'b1);
                burst.slots[2] = snfcs_pkg::spi(snfcs_pkg::CMD_SE, 1'b0, 1'b0);
                burst.slots[3] = snfcs_pkg::spi(a[23:16], 1'b0, 1'b0);
                burst.slots[4] = snfcs_pkg::spi(a[15:8], 1'b0, 1'b0);
                burst.slots[5] = snfcs_pkg::spi(a[7:0], 1'b0, 1'b1);
                burst.count    = 3'd6;
                busy_nxt       = '0;
                phase_nxt      = PH_POLL_WAIT;
              end
            end
            default: begin
              burst.slots[0] = snfcs_pkg::spi(snfcs_pkg::CMD_RDID, 1'b0, 1'b0);
              burst.slots[1] = snfcs_pkg::spi(8'h00, 1'b1, 1'b0);
              burst.slots[2] = snfcs_pkg::spi(8'h00, 1'b1, 1'b0);
              burst.slots[3] = snfcs_pkg::spi(8'h00, 1'b1, 1'b1);
              burst.count    = 3'd4;
              idx_nxt        = '0;
              mism_nxt       = 1'b0;
              phase_nxt      = PH_ID_REPLY;
            end
          endcase
        end
      end
      snfcs_pkg::OP_WBYTE: begin
        if (phase_r == PH_PG_DATA) begin
          chunk_nxt      = chunk_r - snfcs_pkg::CHUNK_W'(1);
          rem_nxt        = rem_dec;
          addr_nxt       = addr_r + 24'd1;
          burst.slots[0] = snfcs_pkg::spi(q_data.byte_in, 1'b0,
                                          chunk_r == snfcs_pkg::CHUNK_W'(1));
          burst.count    = 3'd1;
          if (chunk_r == snfcs_pkg::CHUNK_W'(1)) begin
            busy_nxt  = '0;
            phase_nxt = PH_POLL_WAIT;
          end
        end
      end
      snfcs_pkg::OP_REPLY: begin
        case (phase_r)
          PH_RD_DATA: begin
            burst.slots[0] = '{kind: snfcs_pkg::KIND_HOST, byte_out: q_data.byte_in,
                               capture: 1'b0, frame_end: 1'b0, status: snfcs_pkg::ST_OK};
            burst.count    = 3'd2;
            if (rem_r != '0) begin
              burst.slots[1] = snfcs_pkg::spi(8'h00, 1'b1, rem_r == 25'd1);
              rem_nxt        = rem_dec;
            end else begin
              burst.slots[1] = snfcs_pkg::done(snfcs_pkg::ST_OK);
              phase_nxt      = PH_IDLE;
            end
          end
          PH_POLL_REPLY: begin
            if (!q_data.byte_in[0]) begin
              if (kind_r == snfcs_pkg::OP_PROGRAM[1:0]) begin
                r = rem_r;
              end else begin
                a        = addr_r + sector[23:0];
                r        = rem_sec;
                addr_nxt = a;
                rem_nxt  = r;
              end
              if (r == '0) begin
                burst.slots[0] = snfcs_pkg::done(snfcs_pkg::ST_OK);
                burst.count    = 3'd1;
                phase_nxt      = PH_IDLE;
              end else if (kind_r == snfcs_pkg::OP_PROGRAM[1:0]) begin
                burst.slots[0] = snfcs_pkg::spi(snfcs_pkg::CMD_WREN, 1'b0, 1'b1);
                burst.slots[1] = snfcs_pkg::spi(snfcs_pkg::CMD_PP, 1'b0, 1'b0);
                burst.slots[2] = snfcs_pkg::spi(a[23:16], 1'b0, 1'b0);
                burst.slots[3] = snfcs_pkg::spi(a[15:8], 1'b0, 1'b0);
                burst.slots[4] = snfcs_pkg::spi(a[7:0], 1'b0, 1'b0);
                burst.count    = 3'd5;
                chunk_nxt      = (25'(room) < r) ? room : r[snfcs_pkg::CHUNK_W-1:0];
                phase_nxt      = PH_PG_DATA;
              end else begin
                burst.slots[0] = snfcs_pkg::spi(snfcs_pkg::CMD_WREN, 1'b0, 1'b1);
                burst.slots[1] = snfcs_pkg::spi(snfcs_pkg::CMD_SE, 1'b0, 1'b0);
                burst.slots[2] = snfcs_pkg::spi(a[23:16], 1'b0, 1'b0);
                burst.slots[3] = snfcs_pkg::spi(a[15:8], 1'b0, 1'b0);
                burst.slots[4] = snfcs_pkg::spi(a[7:0], 1'b0, 1'b1);
                burst.count    = 3'd5;
                busy_nxt       = '0;
                phase_nxt      = PH_POLL_WAIT;
              end
            end else if (busy_r >= limit) begin
              burst.slots[0] = snfcs_pkg::done(snfcs_pkg::ST_TIMEOUT);
              burst.count    = 3'd1;
              phase_nxt      = PH_IDLE;
            end else begin
              phase_nxt = PH_POLL_WAIT;
            end
          end
          PH_ID_REPLY: begin
            if (q_data.byte_in != want) mism_nxt = 1'b1;
            if (idx_r >= 2'd2) begin
              idx_nxt        = '0;
              burst.slots[0] = snfcs_pkg::done((mism_r || q_data.byte_in != want) ?
                                               snfcs_pkg::ST_ID : snfcs_pkg::ST_OK);
              burst.count    = 3'd1;
              phase_nxt      = PH_IDLE;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          default: begin
          end
        endcase
      end
      snfcs_pkg::OP_TICK: begin
        if (phase_r == PH_POLL_WAIT) begin
          burst.slots[0] = snfcs_pkg::spi(snfcs_pkg::CMD_RDSR, 1'b0, 1'b0);
          burst.slots[1] = snfcs_pkg::spi(8'h00, 1'b1, 1'b1);
          burst.count    = 3'd2;
          if (busy_r != 16'hFFFF) busy_nxt = busy_r + 16'd1;
          phase_nxt = PH_POLL_REPLY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= '0;
      addr_r  <= '0;
      rem_r   <= '0;
      chunk_r <= '0;
      busy_r  <= '0;
      idx_r   <= '0;
      mism_r  <= 1'b0;
      have_r  <= 1'b0;
      pos_r   <= '0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        addr_r  <= addr_nxt;
        rem_r   <= rem_nxt;
        chunk_r <= chunk_nxt;
        busy_r  <= busy_nxt;
        idx_r   <= idx_nxt;
        mism_r  <= mism_nxt;
        have_r  <= (burst.count != '0);
        pos_r   <= '0;
      end else if (have_r && out_ready) begin
        if (last_slot) begin
          have_r <= 1'b0;
        end
        pos_r <= pos_r + snfcs_pkg::SLOT_W'(1);
      end
    end
    if (fire) begin
      burst_r <= burst;
    end
  end

  always_comb begin
    snfcs_pkg::slot_t s;
    s = burst_r.slots[pos_r[2:0]];
    out_data = '{kind: s.kind, byte_out: s.byte_out, capture: s.capture,
                 frame_end: s.frame_end, status: s.status, last: last_slot};
  end
  assign out_valid = have_r;

endmodule
`default_nettype wire
